@@ design/tde_pkg.sv @@
// ----------------------------------------------------------------------------
// Trie dictionary engine package
// Sizes, the node record layout, status and operation codes and the
// controller states shared by the trie dictionary engine.
// ----------------------------------------------------------------------------
package tde_pkg;

   localparam int NODE_COUNT   = 4096;
   localparam int ALPHABET     = 26;
   localparam int MAX_WORD_LEN = 64;

   localparam int ID_W      = $clog2(NODE_COUNT);
   localparam int USED_W    = $clog2(NODE_COUNT + 1);
   localparam int SLOTS     = NODE_COUNT * ALPHABET;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int LETTER_W  = 5;
   localparam int RANK_W    = 5;
   localparam int COUNT_W   = 5;
   localparam int SCAN_W    = $clog2(ALPHABET);
   localparam int DEPTH_W   = 7;
   localparam int FREQ_W    = 24;
   localparam int STATUS_W  = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DEEP    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd3;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef struct packed {
      logic [ALPHABET-1:0] present;
      logic [LETTER_W-1:0] letter;
      logic [DEPTH_W-1:0]  depth;
      logic                mark;
      logic [FREQ_W-1:0]   freq;
   } node_rec_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_NODE,
      ST_ALLOC,
      ST_CHILD,
      ST_MARK,
      ST_SCAN,
      ST_QCHILD
   } state_type;

endpackage

@@ design/trie_dictionary_engine.sv @@
// ----------------------------------------------------------------------------
// Trie dictionary engine
// A 26-ary trie kept in a node memory and a child slot memory. Insert beats
// walk the trie one letter at a time; query beats report on one node.
//
// A request beat is taken when start is high and busy is low. Every request
// gives exactly one response beat, shown for one cycle with rsp_valid high;
// the receiver cannot stall it. The next request may be taken in the cycle
// in which the response is shown.
// An insert beat reads the node record at the cursor and then responds
// for an abandoned or rejected letter, reads the child slot to follow an
// existing child, or writes the child slot and the parent's present bit and
// then writes the new node. When a followed child ends the word, its record
// is read and then marked. The node memory and child memory each have a
// single read port. A query beat responds for an invalid node id, else
// scans the 26 child bits one bit per cycle to find the ranked child.
// After reset the block writes the root record with busy held high.
// ----------------------------------------------------------------------------
module trie_dictionary_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic [tde_pkg::LETTER_W-1:0]       req_letter,
   input  logic                               req_last,
   input  logic signed [tde_pkg::FREQ_W-1:0]  req_word_frequency,
   input  logic [tde_pkg::ID_W-1:0]           req_node_id,
   input  logic [tde_pkg::RANK_W-1:0]         req_child_rank,
   output logic                               rsp_valid,
   output logic [tde_pkg::STATUS_W-1:0]       rsp_status,
   output logic [tde_pkg::ID_W-1:0]           rsp_result_node,
   output logic                               rsp_letter_valid,
   output logic [tde_pkg::LETTER_W-1:0]       rsp_parent_letter,
   output logic [tde_pkg::COUNT_W-1:0]        rsp_child_count,
   output logic                               rsp_is_word,
   output logic signed [tde_pkg::FREQ_W-1:0]  rsp_node_frequency,
   output logic [tde_pkg::DEPTH_W-1:0]        rsp_node_depth
);
   import tde_pkg::*;

   node_rec_type        node_mem [NODE_COUNT];
   logic [ID_W-1:0]     child_mem [SLOTS];

   state_type           state_ff, state_in;
   logic [ID_W-1:0]     cursor_ff, cursor_in;
   logic                abandoned_ff, abandoned_in;
   logic [USED_W-1:0]   used_ff, used_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                op_ff, op_in;
   logic [LETTER_W-1:0] letter_ff, letter_in;
   logic                last_ff, last_in;
   logic [FREQ_W-1:0]   freq_ff, freq_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [RANK_W-1:0]   rank_ff, rank_in;
   logic [SLOT_W-1:0]   base_ff, base_in;
   logic [SCAN_W-1:0]   scan_ff, scan_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                found_ff, found_in;
   logic [SCAN_W-1:0]   found_letter_ff, found_letter_in;

   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_node_ff, rsp_node_in;
   logic                rsp_lvalid_ff, rsp_lvalid_in;
   logic [LETTER_W-1:0] rsp_letter_ff, rsp_letter_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_word_ff, rsp_word_in;
   logic [FREQ_W-1:0]   rsp_freq_ff, rsp_freq_in;
   logic [DEPTH_W-1:0]  rsp_depth_ff, rsp_depth_in;

   logic                node_re, node_we;
   logic [ID_W-1:0]     node_raddr, node_waddr;
   node_rec_type        node_wdata, node_rd_ff;
   logic                child_re, child_we;
   logic [SLOT_W-1:0]   child_addr;
   logic [ID_W-1:0]     child_wdata, child_rd_ff;

   logic                accept;
   logic                table_full;
   logic                bad_letter;
   logic                too_deep;
   logic                has_child;
   logic                scan_done;
   logic [SLOT_W-1:0]   slot;
   logic [ID_W-1:0]     used_id;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign table_full = (used_ff == USED_W'(NODE_COUNT));
   assign bad_letter = (letter_ff >= LETTER_W'(ALPHABET));
   assign too_deep   = (node_rd_ff.depth >= DEPTH_W'(MAX_WORD_LEN));
   assign has_child  = node_rd_ff.present[letter_ff[SCAN_W-1:0]];
   assign scan_done  = (scan_ff == SCAN_W'(ALPHABET - 1));
   assign slot       = base_ff + SLOT_W'(letter_ff);
   assign used_id    = used_ff[ID_W-1:0];

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      if (node_re) begin
         node_rd_ff <= node_mem[node_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (child_we) begin
         child_mem[child_addr] <= child_wdata;
      end
      if (child_re) begin
         child_rd_ff <= child_mem[child_addr];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_NODE;
            end
         end
         ST_NODE: begin
            if (op_ff == OP_QUERY) begin
               state_in = ({1'b0, id_ff} >= used_ff) ? ST_IDLE : ST_SCAN;
            end else if (abandoned_ff || bad_letter || too_deep) begin
               state_in = ST_IDLE;
            end else if (has_child) begin
               state_in = ST_CHILD;
            end else if (table_full) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            state_in = ST_IDLE;
         end
         ST_CHILD: begin
            state_in = last_ff ? ST_MARK : ST_IDLE;
         end
         ST_MARK: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_QCHILD;
            end
         end
         ST_QCHILD: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      node_rec_type rec;

      rec             = node_rd_ff;
      cursor_in       = cursor_ff;
      abandoned_in    = abandoned_ff;
      used_in         = used_ff;
      op_in           = op_ff;
      letter_in       = letter_ff;
      last_in         = last_ff;
      freq_in         = freq_ff;
      id_in           = id_ff;
      rank_in         = rank_ff;
      base_in         = base_ff;
      scan_in         = scan_ff;
      count_in        = count_ff;
      found_in        = found_ff;
      found_letter_in = found_letter_ff;

      rsp_valid_in    = 1'b0;
      rsp_status_in   = STATUS_OK;
      rsp_node_in     = '0;
      rsp_lvalid_in   = 1'b0;
      rsp_letter_in   = '0;
      rsp_count_in    = '0;
      rsp_word_in     = 1'b0;
      rsp_freq_in     = '0;
      rsp_depth_in    = '0;

      node_re         = 1'b0;
      node_we         = 1'b0;
      node_raddr      = cursor_ff;
      node_waddr      = cursor_ff;
      node_wdata      = node_rd_ff;
      child_re        = 1'b0;
      child_we        = 1'b0;
      child_addr      = slot;
      child_wdata     = used_id;

      unique case (state_ff)
         ST_INIT: begin
            node_we    = 1'b1;
            node_waddr = '0;
            node_wdata = '0;
         end
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_op;
               letter_in  = req_letter;
               last_in    = req_last;
               freq_in    = req_word_frequency;
               id_in      = req_node_id;
               rank_in    = req_child_rank;
               node_re    = 1'b1;
               node_raddr = (req_op == OP_QUERY) ? req_node_id : cursor_ff;
               base_in    = SLOT_W'(node_raddr) * SLOT_W'(ALPHABET);
            end
         end
         ST_NODE: begin
            if (op_ff == OP_QUERY) begin
               scan_in  = '0;
               count_in = '0;
               found_in = 1'b0;
               if ({1'b0, id_ff} >= used_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_INVALID;
               end
            end else if (abandoned_ff || bad_letter || too_deep
                         || (!has_child && table_full)) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = cursor_ff;
               if (abandoned_ff) begin
                  rsp_status_in = table_full ? STATUS_FULL : STATUS_DEEP;
               end else if (bad_letter) begin
                  rsp_status_in = STATUS_INVALID;
               end else if (too_deep) begin
                  rsp_status_in = STATUS_DEEP;
               end else begin
                  rsp_status_in = STATUS_FULL;
               end
               if (last_ff) begin
                  cursor_in    = '0;
                  abandoned_in = 1'b0;
               end else begin
                  abandoned_in = 1'b1;
               end
            end else if (has_child) begin
               child_re = 1'b1;
            end else begin
               child_we   = 1'b1;
               node_we    = 1'b1;
               node_waddr = cursor_ff;
               rec.present[letter_ff[SCAN_W-1:0]] = 1'b1;
               node_wdata = rec;
            end
         end
         ST_ALLOC: begin
            node_we            = 1'b1;
            node_waddr         = used_id;
            node_wdata.present = '0;
            node_wdata.letter  = letter_ff;
            node_wdata.depth   = node_rd_ff.depth + 1'b1;
            node_wdata.mark    = last_ff;
            node_wdata.freq    = last_ff ? freq_ff : '0;
            used_in            = used_ff + 1'b1;
            cursor_in          = last_ff ? '0 : used_id;
            rsp_valid_in       = 1'b1;
            rsp_node_in        = used_id;
         end
         ST_CHILD: begin
            cursor_in = child_rd_ff;
            if (last_ff) begin
               node_re    = 1'b1;
               node_raddr = child_rd_ff;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = child_rd_ff;
            end
         end
         ST_MARK: begin
            rec.mark = 1'b1;
            if (!node_rd_ff.mark || ($signed(freq_ff) > $signed(node_rd_ff.freq))) begin
               rec.freq = freq_ff;
            end
            node_we      = 1'b1;
            node_waddr   = cursor_ff;
            node_wdata   = rec;
            cursor_in    = '0;
            rsp_valid_in = 1'b1;
            rsp_node_in  = cursor_ff;
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (node_rd_ff.present[scan_ff]) begin
               count_in = count_ff + 1'b1;
               if (count_ff == COUNT_W'(rank_ff)) begin
                  found_in        = 1'b1;
                  found_letter_in = scan_ff;
               end
            end
            if (scan_done) begin
               child_addr = base_ff + SLOT_W'(found_letter_in);
               child_re   = found_in;
            end
         end
         ST_QCHILD: begin
            rsp_valid_in  = 1'b1;
            rsp_node_in   = found_ff ? child_rd_ff : '0;
            rsp_lvalid_in = (id_ff != '0);
            rsp_letter_in = (id_ff != '0) ? node_rd_ff.letter : '0;
            rsp_count_in  = count_ff;
            rsp_word_in   = node_rd_ff.mark;
            rsp_freq_in   = node_rd_ff.freq;
            rsp_depth_in  = node_rd_ff.depth;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cursor_ff    <= '0;
         abandoned_ff <= 1'b0;
         used_ff      <= USED_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         abandoned_ff <= abandoned_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      letter_ff       <= letter_in;
      last_ff         <= last_in;
      freq_ff         <= freq_in;
      id_ff           <= id_in;
      rank_ff         <= rank_in;
      base_ff         <= base_in;
      scan_ff         <= scan_in;
      count_ff        <= count_in;
      found_ff        <= found_in;
      found_letter_ff <= found_letter_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_node_ff     <= rsp_node_in;
      rsp_lvalid_ff   <= rsp_lvalid_in;
      rsp_letter_ff   <= rsp_letter_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_word_ff     <= rsp_word_in;
      rsp_freq_ff     <= rsp_freq_in;
      rsp_depth_ff    <= rsp_depth_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_node    = rsp_node_ff;
   assign rsp_letter_valid   = rsp_lvalid_ff;
   assign rsp_parent_letter  = rsp_letter_ff;
   assign rsp_child_count    = rsp_count_ff;
   assign rsp_is_word        = rsp_word_ff;
   assign rsp_node_frequency = rsp_freq_ff;
   assign rsp_node_depth     = rsp_depth_ff;

endmodule
